FILE: rtl/core/aes_xts_sector_cipher_core_assert.svh
// Assertion macros shared by the AES-XTS sector cipher RTL.
`ifndef AES_XTS_SECTOR_CIPHER_CORE_ASSERT_SVH
`define AES_XTS_SECTOR_CIPHER_CORE_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define AXC_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks that an implication holds on the clock edge after the condition.
`define AXC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/core/axc_pkg.sv
// Package with types, constants and AES byte functions for the AES-XTS core.
package axc_pkg;

    localparam int unsigned ROUND_KEY_SLOTS_DEF = 15;
    localparam logic [7:0]  TWEAK_POLY          = 8'h87;
    localparam logic [3:0]  NR_MIN              = 4'd10;
    localparam logic [3:0]  NR_MAX              = 4'd14;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_ROUND_COUNT = 1'b0;
    localparam logic [0:0] REG_DIRECTION   = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD_DKEY = 2'd0,
        MODE_LOAD_TKEY = 2'd1,
        MODE_SECTOR    = 2'd2,
        MODE_DATA      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic decrypt;
        logic last;
    } t_round_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = xtime(x);
        end
        gmul = r;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = a;
        // Exponent 254: bits 1..7 set.
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, p);
            p = gmul(p, p);
        end
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        rotl8 = (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] v);
        logic [7:0] b;
        b = ginv(v);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] v);
        inv_sbox_calc = ginv(rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ 8'h05);
    endfunction

    // Constant S-box tables, evaluated at elaboration.
    typedef logic [7:0] t_sbox [256];

    function automatic t_sbox build_sbox(input logic inv);
        t_sbox t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        build_sbox = t;
    endfunction

    localparam t_sbox SBOX     = build_sbox(1'b0);
    localparam t_sbox INV_SBOX = build_sbox(1'b1);

endpackage

FILE: rtl/core/axc_round.sv
// One shared AES round (forward or inverse) with the following round-key add.
module axc_round
    import axc_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  t_round_ctl   i_ctl,
    output logic [127:0] o_state
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    // Byte substitution with row shift, byte 0 in the low bits.
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = i_state[8*i +: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctl.decrypt) begin
                    t[r + 4*c] = INV_SBOX[s[r + 4*((c - r + 4) & 3)]];
                end else begin
                    t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
                end
            end
        end
    end

    // Column mixing, skipped on the last round.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (i_ctl.last) begin
                for (int r = 0; r < 4; r++) m[4*c + r] = t[4*c + r];
            end else if (i_ctl.decrypt) begin
                m[4*c]   = gmul(t[4*c], 8'd14) ^ gmul(t[4*c+1], 8'd11)
                         ^ gmul(t[4*c+2], 8'd13) ^ gmul(t[4*c+3], 8'd9);
                m[4*c+1] = gmul(t[4*c], 8'd9) ^ gmul(t[4*c+1], 8'd14)
                         ^ gmul(t[4*c+2], 8'd11) ^ gmul(t[4*c+3], 8'd13);
                m[4*c+2] = gmul(t[4*c], 8'd13) ^ gmul(t[4*c+1], 8'd9)
                         ^ gmul(t[4*c+2], 8'd14) ^ gmul(t[4*c+3], 8'd11);
                m[4*c+3] = gmul(t[4*c], 8'd11) ^ gmul(t[4*c+1], 8'd13)
                         ^ gmul(t[4*c+2], 8'd9) ^ gmul(t[4*c+3], 8'd14);
            end else begin
                m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
                m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
                m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) o_state[8*i +: 8] = m[i] ^ i_key[8*i +: 8];
    end

endmodule

FILE: rtl/core/aes_xts_sector_cipher_core.sv
// Top level of the AES-XTS sector cipher core: sequencer, key stores and tweak.
//
// The core takes one beat at a time and is not ready while it works. A sector start
// or a data block first reads the round key store, then does the first key add and
// one AES round per step on the single shared round unit, and a data block then
// waits in the output register until it is taken. Blocks are serialized by the
// tweak chain. There is no clearing pass after reset; round keys must be loaded
// before use.
module aes_xts_sector_cipher_core
    import axc_pkg::*;
#(
    parameter int unsigned ROUND_KEY_SLOTS = ROUND_KEY_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: mode[1:0], key_slot[5:2], word_lo[69:6], word_hi[133:70], zero fill to 136
    input  logic [135:0] s_axis_tdata,
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_lo[63:0], out_hi[127:64]
    output logic [127:0] m_axis_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "aes_xts_sector_cipher_core_assert.svh"

    localparam int SLOT_W = $clog2(ROUND_KEY_SLOTS);

    // Configuration registers.
    logic [3:0] r_round_count;
    logic       r_direction;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= NR_MIN;
            r_direction   <= 1'b0;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_ROUND_COUNT) r_round_count <= pwdata[3:0];
            else                             r_direction   <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_ROUND_COUNT) prdata = {28'd0, r_round_count};
            else                             prdata = {31'd0, r_direction};
        end
    end

    // Effective round count, saturated and capped by the key store depth.
    logic [3:0] nr;
    always_comb begin
        nr = r_round_count;
        if (nr < NR_MIN) nr = NR_MIN;
        if (nr > NR_MAX) nr = NR_MAX;
        if (32'(nr) > ROUND_KEY_SLOTS - 1) nr = 4'(ROUND_KEY_SLOTS - 1);
    end

    // Input fields.
    t_mode        in_mode;
    logic [3:0]   in_slot;
    logic [63:0]  in_lo;
    logic [63:0]  in_hi;
    logic         in_acc;
    assign in_mode = t_mode'(s_axis_tdata[1:0]);
    assign in_slot = s_axis_tdata[5:2];
    assign in_lo   = s_axis_tdata[69:6];
    assign in_hi   = s_axis_tdata[133:70];
    assign in_acc  = s_axis_tvalid & s_axis_tready;

    // Round key stores, one 128-bit entry per slot.
    logic [127:0] r_dkeys [ROUND_KEY_SLOTS];
    logic [127:0] r_tkeys [ROUND_KEY_SLOTS];
    logic [127:0] r_key;
    logic [3:0]   r_kidx;
    logic         r_use_tkey;

    always_ff @(posedge i_clk) begin
        if (in_acc && in_slot < 4'(ROUND_KEY_SLOTS)) begin
            if (in_mode == MODE_LOAD_DKEY) r_dkeys[in_slot[SLOT_W-1:0]] <= {in_hi, in_lo};
            if (in_mode == MODE_LOAD_TKEY) r_tkeys[in_slot[SLOT_W-1:0]] <= {in_hi, in_lo};
        end
        if (r_use_tkey) r_key <= r_tkeys[r_kidx[SLOT_W-1:0]];
        else            r_key <= r_dkeys[r_kidx[SLOT_W-1:0]];
    end

    // Sequencer.
    t_state       r_state, n_state;
    logic [3:0]   r_round, n_round;
    logic [127:0] r_blk, n_blk;
    logic [127:0] r_tweak, n_tweak;
    logic [127:0] r_out, n_out;
    logic         r_is_data, n_is_data;
    logic         r_first, n_first;
    logic [3:0]   n_kidx;
    logic         n_use_tkey;
    t_round_ctl   rctl;
    logic [127:0] round_out;
    logic [127:0] tweak_x;

    assign rctl.decrypt = r_is_data & r_direction;
    assign rctl.last    = (r_round == nr);

    axc_round u_round (
        .i_state (r_blk),
        .i_key   (r_key),
        .i_ctl   (rctl),
        .o_state (round_out)
    );

    assign tweak_x = {r_tweak[126:0], 1'b0} ^ {120'd0, r_tweak[127] ? TWEAK_POLY : 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tweak   <= '0;
            r_round   <= '0;
            r_is_data <= 1'b0;
            r_first   <= 1'b0;
            r_kidx    <= '0;
            r_use_tkey <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tweak   <= n_tweak;
            r_round   <= n_round;
            r_is_data <= n_is_data;
            r_first   <= n_first;
            r_kidx    <= n_kidx;
            r_use_tkey <= n_use_tkey;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_out <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_blk      = r_blk;
        n_tweak    = r_tweak;
        n_out      = r_out;
        n_is_data  = r_is_data;
        n_first    = r_first;
        n_kidx     = r_kidx;
        n_use_tkey = r_use_tkey;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (in_mode == MODE_SECTOR || in_mode == MODE_DATA)) begin
                    n_is_data  = (in_mode == MODE_DATA);
                    n_blk      = (in_mode == MODE_DATA) ? ({in_hi, in_lo} ^ r_tweak)
                                                        : {64'd0, in_lo};
                    n_use_tkey = (in_mode == MODE_SECTOR);
                    n_kidx     = 4'd0;
                    n_round    = 4'd0;
                    n_first    = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                // Key for the next step is fetched ahead through the key register.
                n_kidx  = r_kidx + 4'd1;
                n_first = 1'b0;
                if (r_first) begin
                    n_blk = r_blk;
                end else if (r_round == 4'd0) begin
                    n_blk   = r_blk ^ r_key;
                    n_round = 4'd1;
                end else begin
                    n_blk   = round_out;
                    n_round = r_round + 4'd1;
                    if (rctl.last) begin
                        if (r_is_data) begin
                            n_out   = round_out ^ r_tweak;
                            n_tweak = tweak_x;
                            n_state = ST_OUT;
                        end else begin
                            n_tweak = round_out;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tdata = r_out;

    // Checks on the sequencer.
    `AXC_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready,
        "input accepted while busy")
    `AXC_ASSERT_IMPL(a_round_bound, i_clk, i_rst_n, r_state == ST_RUN, r_round <= nr,
        "round counter past last round")
    `AXC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(r_out), "result changed while stalled")

endmodule
